>>> hw/rtl/sps_pkg.sv
package sps_pkg;

  localparam int TGT_W   = 24;
  localparam int TOL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int TICK_W  = 16;
  localparam int INTEG_W = 48;
  localparam int DRIVE_W = 16;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic signed [TGT_W-1:0]  TGT_RST     = '0;
  localparam logic        [TOL_W-1:0]  TOL_RST     = 16'd25;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST  = 16'sd737;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST  = '0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST  = '0;
  localparam logic signed [GAIN_W-1:0] ALIGN_RST   = 16'sd1843;
  localparam logic        [TICK_W-1:0] TIMEOUT_RST = 16'd100;
  localparam logic        [TICK_W-1:0] TICK_MAX    = '1;

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_TOL     = 3'd1,
    REG_GAIN_P  = 3'd2,
    REG_GAIN_I  = 3'd3,
    REG_GAIN_D  = 3'd4,
    REG_ALIGN   = 3'd5,
    REG_TIMEOUT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic drive;
    logic done;
    logic tmo;
    logic clr;
  } step_flags_t;

endpackage

>>> hw/rtl/strafe_pid_step.sv
// Channel  | Dir | Handshake          | Payload
// in_      | in  | in_tvalid/tready   | tuser: start_req; tdata: middle, left, right
// out_     | out | out_tvalid/tready  | tuser: done_res, timed_out; tdata: four drives
// cfg_     | in  | APB, pready high   | seven registers at 4*i
//
// One word per cycle sustained while out_tready stays high.
// The rate is set by the update loops on move state and on the integral, each closed through its own registers.
// Synchronous active-low reset clears valid bits, move state and the integral, and loads the configuration
// registers with their defaults. A stalled output holds; bubbles upstream still fill, so in_tready falls
// only when all six stages hold a word.
module strafe_pid_step #(
  parameter int COUNT_BITS     = 24,
  parameter int GAIN_FRAC_BITS = 12,
  localparam int IN_DW = ((3 * COUNT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_DW-1:0]                  in_tdata,  // middle, left, right
  input  logic                              in_tuser,  // start_req
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [4*sps_pkg::DRIVE_W-1:0]     out_tdata, // lf, lb, rf, rb
  output logic [1:0]                        out_tuser, // done_res, timed_out
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sps_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [sps_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [sps_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import sps_pkg::*;

  localparam int CB   = COUNT_BITS;
  localparam int F    = GAIN_FRAC_BITS;
  localparam int XW   = (CB > TGT_W) ? CB : TGT_W;
  localparam int EW   = XW + 1;
  localparam int DW   = XW + 2;
  localparam int RW   = CB + 1;
  localparam int PW   = EW + GAIN_W;
  localparam int PDW  = DW + GAIN_W;
  localparam int PAW  = RW + GAIN_W;
  localparam int IAW  = ((INTEG_W > PW) ? INTEG_W : PW) + 1;
  localparam int SW   = ((INTEG_W > PDW) ? INTEG_W : PDW) + 2;
  localparam int SPW  = SW - F;
  localparam int ALW  = PAW - F;
  localparam int MW   = ((SPW > ALW) ? SPW : ALW) + 2;

  localparam logic signed [IAW-1:0] IMAX =
    signed'({{(IAW - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}});
  localparam logic signed [IAW-1:0] IMIN =
    signed'({{(IAW - INTEG_W + 1){1'b1}}, {(INTEG_W - 1){1'b0}}});
  localparam logic signed [MW-1:0] DMAX =
    signed'({{(MW - DRIVE_W + 1){1'b0}}, {(DRIVE_W - 1){1'b1}}});
  localparam logic signed [MW-1:0] DMIN =
    signed'({{(MW - DRIVE_W + 1){1'b1}}, {(DRIVE_W - 1){1'b0}}});

  // configuration
  logic signed [TGT_W-1:0]  tgt_r;
  logic        [TOL_W-1:0]  tol_r;
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r, align_r;
  logic        [TICK_W-1:0] timeout_r;
  logic                     cfg_we;
  reg_idx_t                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r     <= TGT_RST;
      tol_r     <= TOL_RST;
      gain_p_r  <= GAIN_P_RST;
      gain_i_r  <= GAIN_I_RST;
      gain_d_r  <= GAIN_D_RST;
      align_r   <= ALIGN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET:  tgt_r     <= cfg_pwdata[TGT_W-1:0];
        REG_TOL:     tol_r     <= cfg_pwdata[TOL_W-1:0];
        REG_GAIN_P:  gain_p_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:  gain_i_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:  gain_d_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_ALIGN:   align_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET:  cfg_prdata = CFG_DW'(tgt_r);
      REG_TOL:     cfg_prdata = CFG_DW'(tol_r);
      REG_GAIN_P:  cfg_prdata = CFG_DW'(gain_p_r);
      REG_GAIN_I:  cfg_prdata = CFG_DW'(gain_i_r);
      REG_GAIN_D:  cfg_prdata = CFG_DW'(gain_d_r);
      REG_ALIGN:   cfg_prdata = CFG_DW'(align_r);
      REG_TIMEOUT: cfg_prdata = CFG_DW'(timeout_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic [6:1] v_r;
  logic [7:1] rdy;
  logic [6:1] ld;
  logic [5:0] vin;

  assign vin = {v_r[5:1], in_tvalid};
  always_comb begin
    rdy[7] = out_tready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 1; k <= 6; k++) begin
      ld[k] = rdy[k] && vin[k-1];
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = v_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) v_r[k] <= vin[k-1];
      end
    end
  end

  // stage 1: input word
  logic                 s1_start_r;
  logic [CB-1:0]        s1_mid_r, s1_lft_r, s1_rgt_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_start_r <= in_tuser;
      s1_mid_r   <= in_tdata[CB-1:0];
      s1_lft_r   <= in_tdata[2*CB-1:CB];
      s1_rgt_r   <= in_tdata[3*CB-1:2*CB];
    end
  end

  // stage 2: move state, window and timeout checks, errors
  logic [CB-1:0]          org_mid_r, org_lft_r, org_rgt_r;
  logic signed [EW-1:0]   prev_r;
  logic [TICK_W-1:0]      tick_r;
  logic                   active_r;

  logic [CB-1:0]          om, ol, orr;
  logic signed [CB-1:0]   disp, ltrav, rtrav;
  logic signed [DW-1:0]   dispx, win_lo, win_hi, tolx;
  logic [TICK_W-1:0]      tick_base;
  logic signed [EW-1:0]   prev_base, err;
  logic signed [DW-1:0]   derr;
  logic signed [RW-1:0]   drift;
  logic                   act_base, arrived, expired;
  step_flags_t            fl2;

  always_comb begin
    om        = s1_start_r ? s1_mid_r : org_mid_r;
    ol        = s1_start_r ? s1_lft_r : org_lft_r;
    orr       = s1_start_r ? s1_rgt_r : org_rgt_r;
    disp      = signed'(s1_mid_r - om);
    ltrav     = signed'(s1_lft_r - ol);
    rtrav     = signed'(s1_rgt_r - orr);
    tolx      = signed'({{(DW - TOL_W){1'b0}}, tol_r});
    dispx     = DW'(disp);
    win_lo    = DW'(tgt_r) - tolx;
    win_hi    = DW'(tgt_r) + tolx;
    arrived   = (dispx >= win_lo) && (dispx <= win_hi);
    tick_base = s1_start_r ? '0 : tick_r;
    expired   = tick_base >= timeout_r;
    act_base  = s1_start_r | active_r;
    err       = EW'(disp) - EW'(tgt_r);
    prev_base = s1_start_r ? -EW'(tgt_r) : prev_r;
    derr      = DW'(err) - DW'(prev_base);
    drift     = RW'(rtrav) - RW'(ltrav);
    fl2.drive = act_base & !arrived & !expired;
    fl2.done  = act_base & (arrived | expired);
    fl2.tmo   = act_base & !arrived & expired;
    fl2.clr   = s1_start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_mid_r <= '0;
      org_lft_r <= '0;
      org_rgt_r <= '0;
      prev_r    <= '0;
      tick_r    <= '0;
      active_r  <= 1'b0;
    end else if (ld[2]) begin
      org_mid_r <= om;
      org_lft_r <= ol;
      org_rgt_r <= orr;
      prev_r    <= fl2.drive ? err : prev_base;
      tick_r    <= (fl2.drive && tick_base != TICK_MAX) ? tick_base + 1'b1 : tick_base;
      active_r  <= fl2.drive;
    end
  end

  step_flags_t          s2_fl_r;
  logic signed [EW-1:0] s2_err_r;
  logic signed [DW-1:0] s2_derr_r;
  logic signed [RW-1:0] s2_drift_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_fl_r    <= fl2;
      s2_err_r   <= err;
      s2_derr_r  <= derr;
      s2_drift_r <= drift;
    end
  end

  // stage 3: products
  step_flags_t           s3_fl_r;
  logic signed [PW-1:0]  s3_pp_r, s3_pi_r;
  logic signed [PDW-1:0] s3_pd_r;
  logic signed [PAW-1:0] s3_pa_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_fl_r <= s2_fl_r;
      s3_pp_r <= PW'(s2_err_r) * PW'(gain_p_r);
      s3_pi_r <= PW'(s2_err_r) * PW'(gain_i_r);
      s3_pd_r <= PDW'(s2_derr_r) * PDW'(gain_d_r);
      s3_pa_r <= PAW'(s2_drift_r) * PAW'(align_r);
    end
  end

  // stage 4: saturating integral
  logic signed [INTEG_W-1:0] integ_r, integ_base;
  logic signed [IAW-1:0]     isum;
  logic signed [INTEG_W-1:0] isat;

  always_comb begin
    integ_base = s3_fl_r.clr ? '0 : integ_r;
    isum       = IAW'(integ_base) + IAW'(s3_pi_r);
    if (isum > IMAX)      isat = IMAX[INTEG_W-1:0];
    else if (isum < IMIN) isat = IMIN[INTEG_W-1:0];
    else                  isat = isum[INTEG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (ld[4]) begin
      integ_r <= s3_fl_r.drive ? isat : integ_base;
    end
  end

  step_flags_t           s4_fl_r;
  logic signed [PW-1:0]  s4_pp_r;
  logic signed [PDW-1:0] s4_pd_r;
  logic signed [PAW-1:0] s4_pa_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_fl_r <= s3_fl_r;
      s4_pp_r <= s3_pp_r;
      s4_pd_r <= s3_pd_r;
      s4_pa_r <= s3_pa_r;
    end
  end

  // stage 5: PID sum, scale down
  logic signed [SW-1:0]  sum;
  step_flags_t           s5_fl_r;
  logic signed [SPW-1:0] s5_speed_r;
  logic signed [ALW-1:0] s5_align_r;

  assign sum = SW'(s4_pp_r) + SW'(integ_r) + SW'(s4_pd_r);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_fl_r    <= s4_fl_r;
      s5_speed_r <= sum[SW-1:F];
      s5_align_r <= s4_pa_r[PAW-1:F];
    end
  end

  // stage 6: mix and saturate into the output register
  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [MW-1:0] x);
    logic signed [DRIVE_W-1:0] y;
    if (x > DMAX)      y = DMAX[DRIVE_W-1:0];
    else if (x < DMIN) y = DMIN[DRIVE_W-1:0];
    else               y = x[DRIVE_W-1:0];
    return y;
  endfunction

  logic signed [MW-1:0]      spx, alx;
  logic signed [DRIVE_W-1:0] lf, lb, rf, rb;

  always_comb begin
    spx = MW'(s5_speed_r);
    alx = MW'(s5_align_r);
    lf  = sat_drive(alx - spx);
    lb  = sat_drive(spx + alx);
    rf  = sat_drive(spx - alx);
    rb  = sat_drive(-spx - alx);
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      out_tdata <= s5_fl_r.drive ? {rb, rf, lb, lf} : '0;
      out_tuser <= {s5_fl_r.tmo, s5_fl_r.done};
    end
  end

  a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("timed_out without done");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("drives not zero on done");

  a_start_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ld[2] && s1_start_r |=> tick_r <= TICK_W'(1))
    else $error("tick count not restarted");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ld[2] && !s1_start_r && !active_r |=> $stable(tick_r) && $stable(prev_r))
    else $error("idle word changed move state");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ld[4] && !s3_fl_r.drive && !s3_fl_r.clr |=> $stable(integ_r))
    else $error("integral moved on a non-driving word");

endmodule

>>> sim/tb_strafe_pid_step.sv
module tb_strafe_pid_step;
  import sps_pkg::*;

  localparam int CNT_W  = 24;
  localparam int Q_FRAC = 12;

  typedef struct {
    logic [DRIVE_W-1:0] lf;
    logic [DRIVE_W-1:0] lb;
    logic [DRIVE_W-1:0] rf;
    logic [DRIVE_W-1:0] rb;
    logic               done;
    logic               tmo;
  } drive_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [3*CNT_W-1:0]      in_tdata = '0;  // middle, left, right
  logic                    in_tuser = 1'b0; // start_req
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [4*DRIVE_W-1:0]    out_tdata;      // lf, lb, rf, rb
  logic [1:0]              out_tuser;      // done_res, timed_out
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]       cfg_paddr = '0;
  logic [CFG_DW-1:0]       cfg_pwdata = '0;
  logic [CFG_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  strafe_pid_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // controller model state
  logic signed [TGT_W-1:0]  tgt_cnt = TGT_RST;
  logic        [TOL_W-1:0]  tol_cnt = TOL_RST;
  logic signed [GAIN_W-1:0] kp = GAIN_P_RST;
  logic signed [GAIN_W-1:0] ki = GAIN_I_RST;
  logic signed [GAIN_W-1:0] kd = GAIN_D_RST;
  logic signed [GAIN_W-1:0] ka = ALIGN_RST;
  logic        [TICK_W-1:0] tmo_lim = TIMEOUT_RST;
  logic        [CNT_W-1:0]  org_mid = '0;
  logic        [CNT_W-1:0]  org_left = '0;
  logic        [CNT_W-1:0]  org_right = '0;
  longint                   prev_err = 0;
  longint                   integ = 0;
  logic        [TICK_W-1:0] ticks = '0;
  bit                       moving = 1'b0;

  drive_word_t drive_q[$];
  int  n_errs = 0;
  int  n_sent = 0;
  int  n_results = 0;
  int  n_moves = 0;
  int  n_arrived = 0;
  int  n_timeouts = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  rx_hold = 0;

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  function automatic longint rand_s24();
    return longint'(signed'(24'($urandom)));
  endfunction

  function automatic longint rel_travel(logic [CNT_W-1:0] now, logic [CNT_W-1:0] org);
    logic [CNT_W-1:0] d;
    d = now - org;
    return longint'(signed'(d));
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  task automatic predict_drives(bit start, logic [CNT_W-1:0] mid, logic [CNT_W-1:0] lft,
                                logic [CNT_W-1:0] rgt);
    drive_word_t w;
    longint      disp, err, drift, total, speed, align_t;
    bit          arrived, expired;
    w = '{default: '0};
    if (start) begin
      org_mid   = mid;
      org_left  = lft;
      org_right = rgt;
      integ     = 0;
      ticks     = '0;
      prev_err  = -longint'(tgt_cnt);
      moving    = 1'b1;
      n_moves++;
    end
    if (moving) begin
      disp    = rel_travel(mid, org_mid);
      arrived = disp >= longint'(tgt_cnt) - longint'(tol_cnt) &&
                disp <= longint'(tgt_cnt) + longint'(tol_cnt);
      expired = ticks >= tmo_lim;
      if (arrived || expired) begin
        moving = 1'b0;
        w.done = 1'b1;
        w.tmo  = !arrived;
        if (arrived) n_arrived++;
        else n_timeouts++;
      end else begin
        err      = disp - longint'(tgt_cnt);
        integ    = clip(integ + err * longint'(ki), INTEG_W);
        total    = err * longint'(kp) + integ + (err - prev_err) * longint'(kd);
        prev_err = err;
        speed    = total >>> Q_FRAC;
        drift    = rel_travel(rgt, org_right) - rel_travel(lft, org_left);
        align_t  = (drift * longint'(ka)) >>> Q_FRAC;
        if (ticks != TICK_MAX) ticks = ticks + 1'b1;
        w.lf = DRIVE_W'(clip(-speed + align_t, DRIVE_W));
        w.lb = DRIVE_W'(clip(speed + align_t, DRIVE_W));
        w.rf = DRIVE_W'(clip(speed - align_t, DRIVE_W));
        w.rb = DRIVE_W'(clip(-speed - align_t, DRIVE_W));
      end
    end
    drive_q.push_back(w);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (n_errs < 50)
      $display("ERROR result %0d: %s got 0x%0h expected 0x%0h", n_results, what, got, want);
    n_errs++;
  endtask

  always @(negedge clk) begin : check_drives
    drive_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = drive_q.pop_front();
        if (out_tdata[15:0] !== want.lf) report_mismatch("drive_left_front", out_tdata[15:0], want.lf);
        if (out_tdata[31:16] !== want.lb) report_mismatch("drive_left_back", out_tdata[31:16], want.lb);
        if (out_tdata[47:32] !== want.rf) report_mismatch("drive_right_front", out_tdata[47:32], want.rf);
        if (out_tdata[63:48] !== want.rb) report_mismatch("drive_right_back", out_tdata[63:48], want.rb);
        if (out_tuser[0] !== want.done) report_mismatch("done_res", out_tuser[0], want.done);
        if (out_tuser[1] !== want.tmo) report_mismatch("timed_out", out_tuser[1], want.tmo);
      end
      n_results++;
    end
  end

  // hold off the result side in random bursts
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(bit start, logic [CNT_W-1:0] mid, logic [CNT_W-1:0] lft,
                           logic [CNT_W-1:0] rgt);
    bit ok;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {rgt, lft, mid};
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end
    n_sent++;
    predict_drives(start, mid, lft, rgt);
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, longint val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET:  tgt_cnt = val[TGT_W-1:0];
      REG_TOL:     tol_cnt = val[TOL_W-1:0];
      REG_GAIN_P:  kp = val[GAIN_W-1:0];
      REG_GAIN_I:  ki = val[GAIN_W-1:0];
      REG_GAIN_D:  kd = val[GAIN_W-1:0];
      REG_ALIGN:   ka = val[GAIN_W-1:0];
      REG_TIMEOUT: tmo_lim = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(longint t_v, longint tol_v, longint p_v, longint i_v, longint d_v,
                          longint a_v, longint tmo_v);
    cfg_write(REG_TARGET, t_v);
    cfg_write(REG_TOL, tol_v);
    cfg_write(REG_GAIN_P, p_v);
    cfg_write(REG_GAIN_I, i_v);
    cfg_write(REG_GAIN_D, d_v);
    cfg_write(REG_ALIGN, a_v);
    cfg_write(REG_TIMEOUT, tmo_v);
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return longint'(signed'(16'($urandom)));
      default: return pick(-3000, 3000);
    endcase
  endfunction

  task automatic random_regs();
    longint t_v, tol_v, tmo_v;
    case ($urandom_range(0, 7))
      0: t_v = -8388608;
      1: t_v = 8388607;
      2: t_v = rand_s24();
      default: t_v = pick(-20000, 20000);
    endcase
    case ($urandom_range(0, 7))
      0: tol_v = 0;
      1: tol_v = 65535;
      default: tol_v = pick(0, 400);
    endcase
    case ($urandom_range(0, 9))
      0: tmo_v = 0;
      1: tmo_v = 65535;
      2: tmo_v = pick(1, 3);
      default: tmo_v = pick(8, 80);
    endcase
    set_regs(t_v, tol_v, pick_gain(), pick_gain(), pick_gain(), pick_gain(), tmo_v);
  endtask

  task automatic test_idle_and_defaults();
    send_word(1'b0, 24'h000000, 24'h7FFFFF, 24'h800000);
    send_word(1'b0, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
    send_word(1'b1, 24'h800000, 24'h7FFFFF, 24'h000000);
    send_word(1'b0, 24'h123456, 24'hABCDEF, 24'h555555);
    drain_all();
  endtask

  task automatic test_gain_extremes();
    set_regs(1000, 0, 32767, -32768, 32767, -32768, 3);
    send_word(1'b1, 24'h7FFFFF, 24'h800000, 24'h000000);
    send_word(1'b0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    send_word(1'b0, 24'hFFFFFF, 24'h000000, 24'h7FFFFF);
    send_word(1'b1, 24'h000000, 24'hFFFFFF, 24'h800000);
    send_word(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h000000);
    send_word(1'b0, 24'h800000, 24'h000000, 24'h7FFFFF);
    send_word(1'b0, 24'h000010, 24'h000020, 24'h000030);
    send_word(1'b0, 24'h000010, 24'h000020, 24'h000030);
    drain_all();
  endtask

  task automatic test_timeout_edges();
    set_regs(0, 0, 737, 0, 0, 1843, 0);
    send_word(1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
    drain_all();
    cfg_write(REG_TARGET, 500);
    send_word(1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
    send_word(1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
    drain_all();
  endtask

  task automatic test_wide_window();
    set_regs(-8388608, 65535, 737, 5, -7, 1843, 65535);
    send_word(1'b1, 24'h000000, 24'h000000, 24'h000000);
    send_word(1'b0, 24'h400000, 24'h3FF000, 24'h401000);
    send_word(1'b0, 24'h800000, 24'h7FFFFF, 24'h800001);
    drain_all();
  endtask

  // push the integral into its positive clamp, then pull it back through zero
  task automatic test_integral_clip();
    logic [CNT_W-1:0] om, ol, orr;
    int k;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    set_regs(8388607, 0, 0, -32768, 0, pick(-40, 40), 65535);
    om  = 24'($urandom);
    ol  = 24'($urandom);
    orr = 24'($urandom);
    send_word(1'b1, om, ol, orr);
    for (k = 0; k < 270; k++)
      send_word(1'b0, om + 24'h800000, ol + 24'(pick(-500, 500)), orr + 24'(pick(-500, 500)));
    drain_all();
    cfg_write(REG_TARGET, -8388608);
    for (k = 0; k < 280; k++)
      send_word(1'b0, om + 24'h7FFFFF, ol + 24'(pick(-500, 500)), orr + 24'(pick(-500, 500)));
    drain_all();
  endtask

  task automatic test_random_moves(int n_words, bit tx_on, bit rx_on);
    logic [CNT_W-1:0] om, ol, orr;
    longint pos, dl, dr, goal;
    int k, roll;
    tx_idle_on = tx_on;
    rx_idle_on = rx_on;
    random_regs();
    goal = longint'(tgt_cnt);
    om = '0;
    ol = '0;
    orr = '0;
    pos = 0;
    dl = 0;
    dr = 0;
    for (k = 0; k < n_words; k++) begin
      roll = $urandom_range(0, 99);
      if (!moving && roll < 15) begin
        send_word(1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
      end else if (!moving || roll < 4) begin
        om  = 24'($urandom);
        ol  = 24'($urandom);
        orr = 24'($urandom);
        pos = 0;
        dl  = 0;
        dr  = 0;
        send_word(1'b1, om, ol, orr);
      end else if (roll < 9) begin
        send_word(1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
      end else begin
        pos = pos + (goal - pos) / pick(1, 4) + pick(-30, 30);
        if (roll < 14) dl = rand_s24();
        else dl = dl + pick(-60, 60);
        dr = dr + pick(-60, 60);
        send_word(1'b0, om + 24'(pos), ol + 24'(pos + dl), orr + 24'(pos + dr));
      end
    end
    drain_all();
  endtask

  initial begin
    int ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_defaults();
    test_gain_extremes();
    test_timeout_edges();
    test_wide_window();
    test_integral_clip();
    for (ph = 0; ph < 8; ph++)
      test_random_moves(60, ph != 2 && ph != 7, ph != 2 && ph < 6);
    repeat (12) @(posedge clk);
    $display("Sent %0d words, checked %0d results; %0d moves, %0d arrived, %0d timed out.",
             n_sent, n_results, n_moves, n_arrived, n_timeouts);
    $display("Swept gain, window and timeout extremes and the integral clamp; %0d mismatches.",
             n_errs);
    if (n_errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sps_pkg.sv
hw/rtl/strafe_pid_step.sv
sim/tb_strafe_pid_step.sv
